// ----- hdl/irpd_pkg.sv -----
`default_nettype none
package irpd_pkg;

  localparam int CODE_BITS   = 24;
  localparam int CODE_W      = 24;
  localparam int TIME_W      = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int NUM_BYTES   = CODE_BITS / 8;
  localparam int FRAME_BITS  = 16 * NUM_BYTES;
  localparam int BIT_CNT_W   = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MARK  = 8'd0,
    REG_HEADER_SPACE = 8'd1,
    REG_ONE_MARK     = 8'd2,
    REG_ONE_SPACE    = 8'd3,
    REG_ZERO_MARK    = 8'd4,
    REG_ZERO_SPACE   = 8'd5,
    REG_FOOTER_MARK  = 8'd6,
    REG_FOOTER_SPACE = 8'd7
  } cfg_reg_t;

  localparam logic [TIME_W-1:0] RST_HEADER_MARK  = 16'd4692;
  localparam logic [TIME_W-1:0] RST_HEADER_SPACE = 16'd4416;
  localparam logic [TIME_W-1:0] RST_ONE_MARK     = 16'd552;
  localparam logic [TIME_W-1:0] RST_ONE_SPACE    = 16'd1656;
  localparam logic [TIME_W-1:0] RST_ZERO_MARK    = 16'd552;
  localparam logic [TIME_W-1:0] RST_ZERO_SPACE   = 16'd552;
  localparam logic [TIME_W-1:0] RST_FOOTER_MARK  = 16'd552;
  localparam logic [TIME_W-1:0] RST_FOOTER_SPACE = 16'd5244;

  typedef struct packed {
    logic [TIME_W-1:0] header_mark;
    logic [TIME_W-1:0] header_space;
    logic [TIME_W-1:0] one_mark;
    logic [TIME_W-1:0] one_space;
    logic [TIME_W-1:0] zero_mark;
    logic [TIME_W-1:0] zero_space;
    logic [TIME_W-1:0] footer_mark;
    logic [TIME_W-1:0] footer_space;
  } timing_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEADER,
    S_BITS,
    S_FOOTER
  } state_t;

  // Byte k (MSB first) followed by its complement, packed MSB first.
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [CODE_W-1:0] code);
    logic [FRAME_BITS-1:0] frame;
    logic [7:0]            byte_val;
    frame = '0;
    for (int k = 0; k < NUM_BYTES; k++) begin
      byte_val = code[CODE_BITS-8*(k+1) +: 8];
      frame[FRAME_BITS-16*k-1 -: 8]  = byte_val;
      frame[FRAME_BITS-16*k-9 -: 8]  = ~byte_val;
    end
    return frame;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/irpd_code_if.sv -----
`default_nettype none
interface irpd_code_if;
  logic                        valid;
  logic                        ready;
  logic [irpd_pkg::CODE_W-1:0] code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface
`default_nettype wire

// ----- hdl/irpd_pair_if.sv -----
`default_nettype none
interface irpd_pair_if;
  logic                        valid;
  logic                        ready;
  logic [irpd_pkg::TIME_W-1:0] mark_time;
  logic [irpd_pkg::TIME_W-1:0] space_time;
  logic                        last_pair;

  modport source (output valid, output mark_time, output space_time, output last_pair,
                  input ready);
  modport sink   (input valid, input mark_time, input space_time, input last_pair,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/irpd_cfg_if.sv -----
`default_nettype none
interface irpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [irpd_pkg::CFG_IDX_W-1:0] index;
  logic [irpd_pkg::TIME_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ir_pulse_distance_frame_encoder.sv -----
`default_nettype none
// Channel   Role    Payload                              Moves
// code_ch   sink    code[23:0]                           one remote code per request
// pair_ch   source  mark_time, space_time, last_pair     one mark/space pair per request
// cfg       sink    index[7:0], data[15:0]               one timing register write
//
// A code is taken while idle, then the sequencer drives header, 16 pairs per
// code byte and footer: 50 pairs, one per cycle while pair_ch does not stall.
// The single frame shift register yields one bit per bit pair. A stall on
// pair_ch freezes the sequencer. code_ch.ready is high only while idle.
// Synchronous reset loads the timing defaults and drops any frame in flight;
// cfg.ready is always high.
module ir_pulse_distance_frame_encoder (
  input  wire logic  clk,
  input  wire logic  rst,
  irpd_code_if.sink  code_ch,
  irpd_pair_if.source pair_ch,
  irpd_cfg_if.sink   cfg
);

  irpd_pkg::timing_t timing;

  irpd_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .timing (timing)
  );

  // Sequencer state
  irpd_pkg::state_t state, state_next;

  // Frame bits, MSB goes out first; shifted left once per emitted bit pair
  logic [irpd_pkg::FRAME_BITS-1:0] frame, frame_next;
  // Bit pairs still to go, minus one
  logic [irpd_pkg::BIT_CNT_W-1:0]  bit_cnt, bit_cnt_next;

  // Output register
  logic                          out_valid, out_valid_next;
  logic [irpd_pkg::TIME_W-1:0]   out_mark, out_mark_next;
  logic [irpd_pkg::TIME_W-1:0]   out_space, out_space_next;
  logic                          out_last, out_last_next;

  logic take_code;   // code request accepted
  logic load;        // output register free for a new pair

  assign code_ch.ready      = (state == irpd_pkg::S_IDLE);
  assign take_code          = code_ch.valid && code_ch.ready;
  assign load               = !out_valid || pair_ch.ready;

  assign pair_ch.valid      = out_valid;
  assign pair_ch.mark_time  = out_mark;
  assign pair_ch.space_time = out_space;
  assign pair_ch.last_pair  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= irpd_pkg::S_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      bit_cnt   <= bit_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    frame     <= frame_next;
    out_mark  <= out_mark_next;
    out_space <= out_space_next;
    out_last  <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    frame_next     = frame;
    bit_cnt_next   = bit_cnt;
    out_mark_next  = out_mark;
    out_space_next = out_space;
    out_last_next  = out_last;
    // a taken pair empties the register unless a new one lands below
    out_valid_next = out_valid && !pair_ch.ready;

    case (state)
      irpd_pkg::S_IDLE: begin
        if (take_code) begin
          frame_next   = irpd_pkg::build_frame(code_ch.code);
          bit_cnt_next = irpd_pkg::BIT_CNT_W'(irpd_pkg::FRAME_BITS - 1);
          state_next   = irpd_pkg::S_HEADER;
        end
      end
      irpd_pkg::S_HEADER: begin
        if (load) begin
          out_valid_next = 1'b1;
          out_mark_next  = timing.header_mark;
          out_space_next = timing.header_space;
          out_last_next  = 1'b0;
          state_next     = irpd_pkg::S_BITS;
        end
      end
      irpd_pkg::S_BITS: begin
        if (load) begin
          out_valid_next = 1'b1;
          out_last_next  = 1'b0;
          if (frame[irpd_pkg::FRAME_BITS-1]) begin
            out_mark_next  = timing.one_mark;
            out_space_next = timing.one_space;
          end else begin
            out_mark_next  = timing.zero_mark;
            out_space_next = timing.zero_space;
          end
          frame_next = {frame[irpd_pkg::FRAME_BITS-2:0], 1'b0};
          if (bit_cnt == '0) begin
            state_next = irpd_pkg::S_FOOTER;
          end else begin
            bit_cnt_next = bit_cnt - 1'b1;
          end
        end
      end
      irpd_pkg::S_FOOTER: begin
        if (load) begin
          out_valid_next = 1'b1;
          out_mark_next  = timing.footer_mark;
          out_space_next = timing.footer_space;
          out_last_next  = 1'b1;
          state_next     = irpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = irpd_pkg::S_IDLE;
      end
    endcase
  end

  // A new code always starts with the header pair.
  a_code_starts_header: assert property (@(posedge clk) disable iff (rst)
    take_code |=> state == irpd_pkg::S_HEADER)
    else $error("code accepted without moving to header");

  // Footer load puts a last pair in the output register.
  a_footer_flags_last: assert property (@(posedge clk) disable iff (rst)
    (state == irpd_pkg::S_FOOTER && load) |=> (out_valid && out_last))
    else $error("footer pair missing last flag");

  // A held last pair waits only in idle or ahead of the next frame's header.
  a_last_only_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |->
      (state == irpd_pkg::S_IDLE || state == irpd_pkg::S_HEADER))
    else $error("last pair shown while frame still running");

  // Final bit pair hands over to the footer.
  a_bits_to_footer: assert property (@(posedge clk) disable iff (rst)
    (state == irpd_pkg::S_BITS && load && bit_cnt == '0) |=> state == irpd_pkg::S_FOOTER)
    else $error("bit count ran out without footer");

endmodule
`default_nettype wire

// ----- hdl/irpd_cfg.sv -----
`default_nettype none
module irpd_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  irpd_cfg_if.sink         cfg,
  output irpd_pkg::timing_t timing
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.header_mark  <= irpd_pkg::RST_HEADER_MARK;
      timing.header_space <= irpd_pkg::RST_HEADER_SPACE;
      timing.one_mark     <= irpd_pkg::RST_ONE_MARK;
      timing.one_space    <= irpd_pkg::RST_ONE_SPACE;
      timing.zero_mark    <= irpd_pkg::RST_ZERO_MARK;
      timing.zero_space   <= irpd_pkg::RST_ZERO_SPACE;
      timing.footer_mark  <= irpd_pkg::RST_FOOTER_MARK;
      timing.footer_space <= irpd_pkg::RST_FOOTER_SPACE;
    end else if (cfg.valid) begin
      case (cfg.index)
        irpd_pkg::REG_HEADER_MARK:  timing.header_mark  <= cfg.data;
        irpd_pkg::REG_HEADER_SPACE: timing.header_space <= cfg.data;
        irpd_pkg::REG_ONE_MARK:     timing.one_mark     <= cfg.data;
        irpd_pkg::REG_ONE_SPACE:    timing.one_space    <= cfg.data;
        irpd_pkg::REG_ZERO_MARK:    timing.zero_mark    <= cfg.data;
        irpd_pkg::REG_ZERO_SPACE:   timing.zero_space   <= cfg.data;
        irpd_pkg::REG_FOOTER_MARK:  timing.footer_mark  <= cfg.data;
        irpd_pkg::REG_FOOTER_SPACE: timing.footer_space <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule
`default_nettype wire
